@@ rtl/hsr_pkg.sv @@
// ----------------------------------------------------------------------------
// History sparkline renderer package
// Transaction types, fixed field widths and the glyph table for the block.
// ----------------------------------------------------------------------------
package hsr_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int GLYPH_W    = 7;
    localparam int CFG_W      = 6;
    localparam int MAX_GLYPHS = 32;

    // Scaling and quantization constants.
    localparam int SCALE      = 1000;
    localparam int QUANT_MUL  = 9;
    localparam int QUANT_DIV  = 1001;
    localparam int LEVELS     = 9;

    // Divider geometry: a positive sample times the scale fits in LEVEL_NUM_W
    // bits, and the quotient never exceeds the scale.
    localparam int LEVEL_NUM_W = 25;
    localparam int LEVEL_W     = 10;
    localparam int LEVEL_IDX_W = 4;
    localparam int STEP_W      = 4;

    // Function codes.
    localparam logic FUNC_PUSH   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // ASCII space, used for empty positions and the lowest level.
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;

    // One input transaction.
    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample_value;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               last;
    } result_t;

    // Glyph for each quantized level, from empty to full.
    function automatic logic [GLYPH_W-1:0] glyph_code(input logic [LEVEL_IDX_W-1:0] lvl);
        logic [GLYPH_W-1:0] g;
        case (lvl)
            4'd0:    g = 7'd32;  // space
            4'd1:    g = 7'd46;  // .
            4'd2:    g = 7'd58;  // :
            4'd3:    g = 7'd45;  // -
            4'd4:    g = 7'd61;  // =
            4'd5:    g = 7'd43;  // +
            4'd6:    g = 7'd42;  // *
            4'd7:    g = 7'd35;  // #
            4'd8:    g = 7'd64;  // @
            default: g = 7'd32;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/hsr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module hsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/history_sparkline_renderer.sv @@
// ----------------------------------------------------------------------------
// History sparkline renderer
// Sample history in a ring buffer and an iterative sparkline renderer.
// ----------------------------------------------------------------------------
// A push transaction (func = 0) stores one sample and gives no result. A
// render transaction (func = 1) emits W glyphs, W being display_width
// clamped to 1..min(HISTORY_DEPTH, 32), one per result_valid pulse, with
// last set on the final one; the receiver cannot stall, so each glyph must
// be taken in the cycle it appears. The render time is set by the single
// RAM read port and by the shared restoring divider, which produces one
// quotient bit per cycle. busy is high for the whole render and start is
// ignored meanwhile.
// ----------------------------------------------------------------------------
module history_sparkline_renderer #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  hsr_pkg::cmd_t              cmd,
    input  logic                       cfg_wr_en,
    input  logic [hsr_pkg::CFG_W-1:0]  cfg_wr_data,
    output logic                       result_valid,
    output hsr_pkg::result_t           result
);

    import hsr_pkg::*;

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int XW   = (CW > CFG_W) ? CW : CFG_W;
    localparam int WMAX = (HISTORY_DEPTH < MAX_GLYPHS) ? HISTORY_DEPTH : MAX_GLYPHS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAX_RD,
        ST_MAX_CMP,
        ST_GL_RD,
        ST_GL_LOAD,
        ST_GL_DIV,
        ST_GL_EMIT
    } state_t;

    // Control and datapath registers.
    state_t                       state_reg,        state_next;
    logic [CW-1:0]                count_reg,        count_next;
    logic [AW-1:0]                oldest_reg,       oldest_next;
    logic [CFG_W-1:0]             dwidth_reg;
    logic [CFG_W-1:0]             width_reg,        width_next;
    logic [CFG_W-1:0]             nvalid_reg,       nvalid_next;
    logic [CFG_W-1:0]             j_reg,            j_next;
    logic [CW-1:0]                idx_reg,          idx_next;
    logic signed [SAMPLE_W-1:0]   vmax_reg,         vmax_next;
    logic [LEVEL_NUM_W-1:0]       rem_reg,          rem_next;
    logic [LEVEL_NUM_W-1:0]       dvs_reg,          dvs_next;
    logic [LEVEL_W-1:0]           q_reg,            q_next;
    logic [STEP_W-1:0]            step_reg,         step_next;
    logic                         result_valid_reg, result_valid_next;
    result_t                      result_reg,       result_next;

    // Memory interface.
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [SAMPLE_W-1:0]          ram_rdata;

    // Helper signals.
    logic                         accept;
    logic                         full;
    logic [CFG_W-1:0]             width_eff;
    logic [LEVEL_IDX_W-1:0]       level_idx;

    // Physical slot of a logical position counted from the oldest sample.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] offs);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, offs};
        if (s >= (AW+1)'(HISTORY_DEPTH))
        begin
            s = s - (AW+1)'(HISTORY_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (count_reg == CW'(HISTORY_DEPTH));
    assign busy   = (state_reg != ST_IDLE);

    // Effective render width: zero means one glyph, large values clamp.
    always_comb
    begin
        if (dwidth_reg == '0)
        begin
            width_eff = CFG_W'(1);
        end
        else if (XW'(dwidth_reg) > XW'(WMAX))
        begin
            width_eff = CFG_W'(WMAX);
        end
        else
        begin
            width_eff = dwidth_reg;
        end
    end

    // Push write goes straight to the memory at the ring tail.
    assign ram_we    = accept && (cmd.func == FUNC_PUSH);
    assign ram_waddr = full ? oldest_reg : slot_of(oldest_reg, count_reg[AW-1:0]);
    assign ram_raddr = slot_of(oldest_reg, idx_reg[AW-1:0]);

    hsr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Quantize the permille level: count the level thresholds that it reaches.
    always_comb
    begin
        level_idx = '0;
        for (int k = 1; k < LEVELS; k++)
        begin
            if (({4'b0, q_reg} * 14'(QUANT_MUL)) >= 14'(k * QUANT_DIV))
            begin
                level_idx = level_idx + LEVEL_IDX_W'(1);
            end
        end
    end

    // Sequencer: window maximum scan, then one divide per glyph of a positive sample.
    always_comb
    begin
        logic                     emit;
        logic [GLYPH_W-1:0]       emit_glyph;
        logic                     is_last;
        logic [CW-1:0]            idx_inc;
        logic                     ge;
        logic [LEVEL_NUM_W-1:0]   diff;

        state_next        = state_reg;
        count_next        = count_reg;
        oldest_next       = oldest_reg;
        width_next        = width_reg;
        nvalid_next       = nvalid_reg;
        j_next            = j_reg;
        idx_next          = idx_reg;
        vmax_next         = vmax_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        q_next            = q_reg;
        step_next         = step_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        emit              = 1'b0;
        emit_glyph        = GLYPH_SPACE;
        is_last           = (j_reg == width_reg - CFG_W'(1));
        idx_inc           = idx_reg + CW'(1);
        ge                = (rem_reg >= dvs_reg);
        diff              = rem_reg - dvs_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == FUNC_PUSH)
                    begin
                        // Append, or overwrite the oldest once full.
                        if (full)
                        begin
                            if (oldest_reg == AW'(HISTORY_DEPTH - 1))
                            begin
                                oldest_next = '0;
                            end
                            else
                            begin
                                oldest_next = oldest_reg + AW'(1);
                            end
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        // Window covers the newest samples, at most width of them.
                        width_next = width_eff;
                        if (XW'(count_reg) > XW'(width_eff))
                        begin
                            nvalid_next = width_eff;
                            idx_next    = count_reg - CW'(width_eff);
                        end
                        else
                        begin
                            nvalid_next = CFG_W'(count_reg);
                            idx_next    = '0;
                        end
                        vmax_next = SAMPLE_W'(1);
                        j_next    = '0;
                        if (count_reg == '0)
                        begin
                            state_next = ST_GL_RD;
                        end
                        else
                        begin
                            state_next = ST_MAX_RD;
                        end
                    end
                end
            end

            ST_MAX_RD:
            begin
                state_next = ST_MAX_CMP;
            end

            ST_MAX_CMP:
            begin
                if ($signed(ram_rdata) > vmax_reg)
                begin
                    vmax_next = $signed(ram_rdata);
                end
                if (idx_inc == count_reg)
                begin
                    idx_next   = count_reg - CW'(nvalid_reg);
                    state_next = ST_GL_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_MAX_RD;
                end
            end

            ST_GL_RD:
            begin
                if (j_reg < nvalid_reg)
                begin
                    state_next = ST_GL_LOAD;
                end
                else
                begin
                    emit = 1'b1;
                end
            end

            ST_GL_LOAD:
            begin
                // Non-positive samples sit at the lowest level.
                if ($signed(ram_rdata) <= 0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    rem_next   = LEVEL_NUM_W'(ram_rdata[SAMPLE_W-2:0]) *
                                 LEVEL_NUM_W'(SCALE);
                    dvs_next   = LEVEL_NUM_W'(vmax_reg[SAMPLE_W-2:0]) << (LEVEL_W - 1);
                    q_next     = '0;
                    step_next  = STEP_W'(LEVEL_W - 1);
                    state_next = ST_GL_DIV;
                end
            end

            ST_GL_DIV:
            begin
                // One restoring division step per cycle.
                if (ge)
                begin
                    rem_next = diff;
                end
                q_next   = {q_reg[LEVEL_W-2:0], ge};
                dvs_next = dvs_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = ST_GL_EMIT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end

            ST_GL_EMIT:
            begin
                emit       = 1'b1;
                emit_glyph = glyph_code(level_idx);
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Present a glyph and advance to the next position.
        if (emit)
        begin
            result_valid_next  = 1'b1;
            result_next.glyph  = emit_glyph;
            result_next.last   = is_last;
            j_next             = j_reg + CFG_W'(1);
            idx_next           = idx_inc;
            state_next         = is_last ? ST_IDLE : ST_GL_RD;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            oldest_reg       <= '0;
            dwidth_reg       <= CFG_W'(32);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            oldest_reg       <= oldest_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en)
            begin
                dwidth_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        nvalid_reg <= nvalid_next;
        j_reg      <= j_next;
        idx_reg    <= idx_next;
        vmax_reg   <= vmax_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        q_reg      <= q_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The stored count never exceeds the history depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HISTORY_DEPTH))
        else $error("sample count exceeds history depth");

    // The ring pointer only moves once the history is full.
    a_oldest_full: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg != '0) |-> full)
        else $error("oldest pointer moved before history filled");

    // A result only follows a cycle in which a render was in progress.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a render in progress");

    // The final glyph of a run returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("block still busy after final glyph");

    // The scaled level never exceeds full scale.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GL_EMIT) |-> (q_reg <= LEVEL_W'(SCALE)))
        else $error("scaled level above full scale");

endmodule

@@ dv/tb_history_sparkline_renderer.sv @@
// ----------------------------------------------------------------------------
// History sparkline renderer testbench
// Drives push and render transactions through the start/busy port. A model
// inside the bench keeps its own sample ring and display width, computes the
// glyphs that each render should give, and compares every glyph strobe with
// the oldest glyph still owed. Directed tests cover empty and short history,
// sample extremes, non-positive samples and width clamping. Random bursts of
// pushes followed by renders then run with the sender idling at several rates.
// ----------------------------------------------------------------------------
module tb_history_sparkline_renderer;

    import hsr_pkg::*;

    localparam int DEPTH = 32;

    // Block ports.
    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    cmd_t              cmd;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              result_valid;
    result_t           result;

    // Sample history and display width as the model tracks them.
    logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];
    int                         hist_count;
    logic [4:0]                 hist_oldest;
    logic [CFG_W-1:0]           width_reg;

    // Glyphs owed by the block, oldest first.
    result_t expected_glyphs [$];

    // Glyph characters from the empty level up to the full level.
    string glyph_ramp = " .:-=+*#@";

    // Run statistics and the error count.
    int sender_idle_pct;
    int pushes_sent;
    int renders_sent;
    int glyphs_checked;
    int mismatches;

    history_sparkline_renderer #(
        .HISTORY_DEPTH (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // Free-running clock with a period of 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Map one sample to its glyph, given the peak of its window.
    function automatic logic [GLYPH_W-1:0] level_to_glyph(input int sample, input int peak);
        int         permille;
        int         idx;
        logic [7:0] ch;
        idx = 0;
        if (sample > 0)
        begin
            permille = (sample * SCALE) / peak;
            if (permille > SCALE)
                permille = SCALE;
            idx = (permille * QUANT_MUL) / QUANT_DIV;
        end
        ch = glyph_ramp[idx];
        return ch[GLYPH_W-1:0];
    endfunction

    // Append one sample; a full ring drops its oldest entry.
    task automatic history_push(input logic signed [SAMPLE_W-1:0] value);
        if (hist_count < DEPTH)
        begin
            hist_mem[(hist_oldest + hist_count) % DEPTH] = value;
            hist_count++;
        end
        else
        begin
            hist_mem[hist_oldest] = value;
            hist_oldest++;
        end
    endtask

    // Queue the glyphs that one render transaction should produce.
    task automatic render_glyphs();
        int      w;
        int      first;
        int      peak;
        int      pos;
        int      s;
        result_t g;
        w = width_reg;
        if (w > DEPTH)
            w = DEPTH;
        if (w > MAX_GLYPHS)
            w = MAX_GLYPHS;
        if (w < 1)
            w = 1;
        first = (hist_count > w) ? hist_count - w : 0;
        // The window peak is taken as at least one.
        peak = 1;
        for (int i = first; i < hist_count; i++)
        begin
            s = hist_mem[(hist_oldest + i) % DEPTH];
            if (s > peak)
                peak = s;
        end
        for (int j = 0; j < w; j++)
        begin
            pos = first + j;
            if (pos >= hist_count)
                g.glyph = GLYPH_SPACE;
            else
                g.glyph = level_to_glyph(hist_mem[(hist_oldest + pos) % DEPTH], peak);
            g.last = (j == w - 1);
            expected_glyphs.push_back(g);
        end
    endtask

    // Compare each glyph strobe with the oldest glyph owed.
    always @(posedge clk)
    begin : glyph_check
        result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_glyphs.size() == 0)
            begin
                $display("%0t: unexpected glyph: expected none, actual glyph %0d last %0b",
                         $time, result.glyph, result.last);
                mismatches++;
            end
            else
            begin
                want = expected_glyphs.pop_front();
                if (result.glyph !== want.glyph)
                begin
                    $display("%0t: glyph mismatch: expected %0d, actual %0d",
                             $time, want.glyph, result.glyph);
                    mismatches++;
                end
                if (result.last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, result.last);
                    mismatches++;
                end
                glyphs_checked++;
            end
        end
    end

    // Send one transaction, idling first at the current rate, and predict it.
    // start stays high on return so that a following transaction can go
    // back to back; every caller either sends again or lowers it at once.
    task automatic send_cmd(input logic fn, input logic signed [SAMPLE_W-1:0] value);
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(100, 20) : $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        cmd.func         <= fn;
        cmd.sample_value <= value;
        do
            @(posedge clk);
        while (busy);
        if (fn == FUNC_PUSH)
        begin
            history_push(value);
            pushes_sent++;
        end
        else
        begin
            render_glyphs();
            renders_sent++;
        end
    endtask

    task automatic send_render();
        send_cmd(FUNC_RENDER, SAMPLE_W'($urandom));
    endtask

    // Stop sending and wait until every owed glyph has arrived and the
    // block has settled.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Write the display width; only called while the block is idle.
    task automatic write_width(input logic [CFG_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        width_reg = w;
        cfg_wr_en <= 1'b0;
    endtask

    // Pick a push value: wide random, non-positive, or positive up to a span.
    function automatic logic signed [SAMPLE_W-1:0] random_sample(input int span);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 20)
            v = $urandom;
        else if (r < 32)
            v = -int'($urandom_range(32768, 0));
        else
            v = $urandom_range(span, 1);
        return SAMPLE_W'(v);
    endfunction

    // Render on an empty history, at the reset width and at width zero.
    task automatic test_empty_history();
        send_render();
        wait_idle();
        write_width(6'd0);
        send_render();
        wait_idle();
    endtask

    // Push the sample extremes and render a window wider than the history.
    task automatic test_sample_extremes();
        write_width(6'd8);
        send_cmd(FUNC_PUSH, 16'sh7FFF);
        send_cmd(FUNC_PUSH, 16'sh8000);
        send_cmd(FUNC_PUSH, 16'sh0000);
        send_cmd(FUNC_PUSH, 16'shFFFF);
        send_cmd(FUNC_PUSH, 16'sh0001);
        send_cmd(FUNC_PUSH, 16'sh4000);
        send_cmd(FUNC_PUSH, 16'sh0E38);
        send_render();
        wait_idle();
    endtask

    // Width of one, the clamp above the depth, exactly the depth, and zero.
    task automatic test_width_clamp();
        logic [CFG_W-1:0] widths [5];
        widths = '{6'd1, 6'd63, 6'd33, 6'd32, 6'd0};
        foreach (widths[i])
        begin
            write_width(widths[i]);
            send_render();
            wait_idle();
        end
    endtask

    // A window of only zero and negative samples renders all spaces.
    task automatic test_non_positive();
        write_width(6'd4);
        send_cmd(FUNC_PUSH, -16'sd5);
        send_cmd(FUNC_PUSH, 16'sd0);
        send_cmd(FUNC_PUSH, 16'sh8000);
        send_cmd(FUNC_PUSH, -16'sd1);
        send_render();
        wait_idle();
    endtask

    // Bursts of pushes, each followed by a render, over several widths.
    task automatic test_random_traffic();
        int sent;
        int burst;
        int span;
        for (int blk = 0; blk < 4; blk++)
        begin
            wait_idle();
            case ($urandom_range(5))
                0:       write_width(6'd0);
                1:       write_width(6'd1);
                2:       write_width(6'd32);
                3:       write_width(6'd63);
                4:       write_width(CFG_W'($urandom_range(63, 33)));
                default: write_width(CFG_W'($urandom_range(31, 2)));
            endcase
            sent = 0;
            while (sent < 13)
            begin
                burst = ($urandom_range(9) < 3) ? 0 : $urandom_range(12, 1);
                case ($urandom_range(3))
                    0:       span = 9;
                    1:       span = 200;
                    2:       span = 1000;
                    default: span = 32767;
                endcase
                repeat (burst)
                begin
                    send_cmd(FUNC_PUSH, random_sample(span));
                    sent++;
                end
                send_render();
                sent++;
            end
        end
        wait_idle();
    endtask

    // Reset, then the directed tests, then random traffic at three idle rates.
    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        for (int i = 0; i < DEPTH; i++)
            hist_mem[i] = '0;
        hist_count      = 0;
        hist_oldest     = '0;
        width_reg       = 6'd32;
        sender_idle_pct = 0;
        pushes_sent     = 0;
        renders_sent    = 0;
        glyphs_checked  = 0;
        mismatches      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_history();
        test_sample_extremes();
        test_width_clamp();
        test_non_positive();

        sender_idle_pct = 18;
        test_random_traffic();
        sender_idle_pct = 77;
        test_random_traffic();
        sender_idle_pct = 0;
        test_random_traffic();

        wait_idle();
        $display("Sent %0d push and %0d render transactions; checked %0d glyphs.",
                 pushes_sent, renders_sent, glyphs_checked);
        $display("Covered empty, short and wrapped history, width clamps, and sender idle rates.");
        if (mismatches == 0)
            $display("tb_history_sparkline_renderer: PASS");
        else
            $display("tb_history_sparkline_renderer: FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4000000;
        $display("tb_history_sparkline_renderer: FAIL");
        $finish;
    end

endmodule
